// File: hdl/history_ring_buffer_defines.svh
// Assertion macros used by the history ring buffer top module.
`ifndef HISTORY_RING_BUFFER_DEFINES_SVH
`define HISTORY_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define HRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define HRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hrb_pkg.sv
// Types, constants and codes of the history ring buffer.
package hrb_pkg;

    localparam int DEPTH  = 16;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = 32;
    localparam int FILL_W = 5;

    localparam logic [1:0] OP_ADD       = 2'd0;
    localparam logic [1:0] OP_READ_NTH  = 2'd1;
    localparam logic [1:0] OP_READ_LAST = 2'd2;
    localparam logic [1:0] OP_CLEAR     = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_SHIFT  = 2'd1;
    localparam logic [1:0] CELL_ROTATE = 2'd2;
    localparam logic [1:0] CELL_WIPE   = 2'd3;

    typedef logic [1:0] cell_mode_t;

    typedef struct packed {
        logic        flag;
        logic [31:0] value;
    } entry_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] item_value;
        logic        item_valid;
        logic [7:0]  back_offset;
        logic        wipe_entries;
    } cmd_t;

    typedef struct packed {
        logic              status;
        logic [31:0]       out_value;
        logic              out_valid;
        logic [CNT_W-1:0]  add_count;
        logic [FILL_W-1:0] fill_level;
    } rsp_t;

endpackage

// File: hdl/hrb_cell.sv
// One ring entry: holds, takes its newer neighbor, takes its older neighbor, or wipes.
module hrb_cell
    import hrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_mode_t mode,
    input  entry_t     newer,
    input  entry_t     older,
    output entry_t     q
);

    entry_t q_reg;
    entry_t q_next;

    always_comb
    begin
        unique case (mode)
            CELL_HOLD:   q_next = q_reg;
            CELL_SHIFT:  q_next = newer;
            CELL_ROTATE: q_next = older;
            CELL_WIPE:   q_next = '0;
            default:     q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: hdl/hrb_search.sv
// Newest-first pick of the first entry with its flag set.
module hrb_search
    import hrb_pkg::*;
(
    input  entry_t entries [DEPTH],
    output logic   found,
    output entry_t pick
);

    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        // walk oldest to newest so the newest hit wins
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (entries[i].flag)
            begin
                found = 1'b1;
                pick  = entries[i];
            end
        end
    end

endmodule

// File: hdl/history_ring_buffer.sv
// History ring buffer: cell i holds the entry i places back from the newest.
// A result strobes in the cycle after its word is accepted.
// Throughput: one word per cycle for add and both reads, while busy is low.
// Clear without wipe re-aligns the cell chain by rotating it one step per cycle,
// so busy stays high until a rotation count loaded from the newest slot number (0 to DEPTH-1) runs down to zero.
// Reset clears all entries, pointer, count and strobe; busy is low after reset.
module history_ring_buffer
    import hrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic strobe,
    output rsp_t result
);

    `include "history_ring_buffer_defines.svh"

    logic [SLOT_W-1:0] newest_reg, newest_next;
    logic              empty_reg, empty_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [SLOT_W-1:0] rot_reg, rot_next;
    logic              strobe_reg;
    rsp_t              rsp_reg, rsp_next;

    logic       accept;
    logic       rotating;
    entry_t     cell_q [DEPTH];
    cell_mode_t cell_mode [DEPTH];
    entry_t     new_entry;
    logic       hit;
    entry_t     hit_entry;
    logic       nth_miss;
    entry_t     nth_entry;
    logic [CNT_W-1:0] fill_wide;

    assign rotating  = (rot_reg != '0);
    assign busy      = rotating;
    assign accept    = start && !busy;
    assign new_entry = '{flag: cmd.item_valid, value: cmd.item_value};

    // cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int OLDER = (i + 1) % DEPTH;
        entry_t newer_in;
        if (i == 0)
        begin : g_head
            assign newer_in = new_entry;
        end
        else
        begin : g_body
            assign newer_in = cell_q[i-1];
        end
        hrb_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .mode  (cell_mode[i]),
            .newer (newer_in),
            .older (cell_q[OLDER]),
            .q     (cell_q[i])
        );
    end

    hrb_search u_search (
        .entries (cell_q),
        .found   (hit),
        .pick    (hit_entry)
    );

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_mode[i] = CELL_HOLD;
            if (rotating)
            begin
                cell_mode[i] = CELL_ROTATE;
            end
            else if (accept && cmd.operation == OP_ADD)
            begin
                // first add after empty lands in the head cell without shifting
                if (!empty_reg || i == 0)
                begin
                    cell_mode[i] = CELL_SHIFT;
                end
            end
            else if (accept && cmd.operation == OP_CLEAR && cmd.wipe_entries)
            begin
                cell_mode[i] = CELL_WIPE;
            end
        end
    end

    assign nth_miss = empty_reg
                   || ({1'b0, cmd.back_offset} >= 9'(DEPTH))
                   || ({{(CNT_W-8){1'b0}}, cmd.back_offset} >= total_reg);
    assign nth_entry = cell_q[cmd.back_offset[SLOT_W-1:0]];

    always_comb
    begin
        newest_next = newest_reg;
        empty_next  = empty_reg;
        total_next  = total_reg;
        rot_next    = rotating ? rot_reg - 1'b1 : rot_reg;
        rsp_next    = '0;
        if (accept)
        begin
            unique case (cmd.operation)
                OP_ADD:
                begin
                    if (empty_reg || newest_reg == SLOT_W'(DEPTH - 1))
                    begin
                        newest_next = '0;
                    end
                    else
                    begin
                        newest_next = newest_reg + 1'b1;
                    end
                    empty_next         = 1'b0;
                    rsp_next.add_count = total_reg;
                    if (total_reg != '1)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                OP_READ_NTH:
                begin
                    if (nth_miss)
                    begin
                        rsp_next.status = 1'b1;
                    end
                    else
                    begin
                        rsp_next.out_value = nth_entry.value;
                        rsp_next.out_valid = nth_entry.flag;
                    end
                end
                OP_READ_LAST:
                begin
                    if (empty_reg || !hit)
                    begin
                        rsp_next.status = 1'b1;
                    end
                    else
                    begin
                        rsp_next.out_value = hit_entry.value;
                        rsp_next.out_valid = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    newest_next = '0;
                    empty_next  = 1'b1;
                    total_next  = '0;
                    // kept entries: bring physical slot 0 back to the head cell
                    if (!cmd.wipe_entries)
                    begin
                        rot_next = newest_reg;
                    end
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
        fill_wide = (total_next >= CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : total_next;
        rsp_next.fill_level = fill_wide[FILL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
            empty_reg  <= 1'b1;
            total_reg  <= '0;
            rot_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            newest_reg <= newest_next;
            empty_reg  <= empty_next;
            total_reg  <= total_next;
            rot_reg    <= rot_next;
            strobe_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = rsp_reg;

    `HRB_ASSERT_NEXT(a_accept_strobes, start && !busy, strobe, "accepted word gave no result")
    `HRB_ASSERT_NOW(a_strobe_has_word, strobe, $past(start && !busy), "result without a word")
    `HRB_ASSERT_NOW(a_empty_count, empty_reg, total_reg == '0 && newest_reg == '0,
                    "empty ring with nonzero count or pointer")
    `HRB_ASSERT_NOW(a_rotate_only_after_clear, rotating && !$past(rotating),
                    empty_reg, "rotation started without a clear")

endmodule
